// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the alternating-bit receiver.
// The macros expect signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/abr_pkg.sv -----
// Package of the alternating-bit receiver: sequencer state type and fixed constants.
// Depends on nothing; used by the top level alternating_bit_receiver.
`default_nettype none

package abr_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IN    = 8'b0000_0001,
		S_H1    = 8'b0000_0010,
		S_H2    = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_A1    = 8'b0001_0000,
		S_A2    = 8'b0010_0000,
		S_SUM   = 8'b0100_0000,
		S_REPLY = 8'b1000_0000
	} state_t;

	// Verdict codes carried on the result beats.
	localparam logic VERDICT_NEW    = 1'b0;
	localparam logic VERDICT_REPLAY = 1'b1;

	// Payload byte of the ack packet held after reset, and its ack number.
	localparam logic [7:0]  FILL_BYTE = 8'h61;
	localparam logic [31:0] INIT_ACK  = 32'd1;

endpackage

`default_nettype wire

// ----- rtl/abr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instantiated by alternating_bit_receiver.
`default_nettype none

module abr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 20,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered: with rd_en high, data is valid in the cycle after the address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/alternating_bit_receiver.sv -----
// Alternating-bit receiver. Input beats are taken one per cycle while a packet streams in.
// After the last beat: checksum work in S_H1, S_H2 and S_CHK, then S_A1, S_A2 and S_SUM
// when a new ack is built. Each reply beat: ack or receive RAM read, then output register.
// Reset: the stored ack is number 1 with all payload bytes 0x61; no clearing pass is run.
// Depends on abr_pkg, abr_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module alternating_bit_receiver #(
	parameter int PAYLOAD_BYTES = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Slave side: received packet bytes.
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s_tdata: payload_byte[7:0], seq_number[39:8], ack_number[71:40],
	// packet_checksum[103:72]
	input  wire logic [103:0] s_tdata,
	input  wire logic         s_tlast,   // byte_last
	// Master side: ack packet bytes.
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m_tdata: reply_number[31:0], reply_checksum[63:32], reply_byte[71:64]
	output logic      [71:0]  m_tdata,
	// m_tuser: verdict[0], deliver[1]
	output logic      [1:0]   m_tuser,
	output logic              m_tlast    // reply_last
);

	import abr_pkg::*;

	localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CW = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [31:0] IDX_TOTAL = 32'(PAYLOAD_BYTES * (PAYLOAD_BYTES - 1) / 2);
	localparam logic [31:0] RESET_CSUM =
		IDX_TOTAL * (32'(FILL_BYTE) + (32'd1 + INIT_ACK) * (32'd2 + INIT_ACK));
	localparam logic [CW-1:0] POS_MAX  = CW'(PAYLOAD_BYTES);
	localparam logic [IW-1:0] IDX_LAST = IW'(PAYLOAD_BYTES - 1);

	state_t state_q;

	// Receive side registers.
	logic [CW-1:0] pos_q;
	logic [31:0]   payload_sum_q;
	logic [CW-1:0] count_q;
	logic [31:0]   sum_q;
	logic [31:0]   seq_q;
	logic [31:0]   ack_q;
	logic [31:0]   pcs_q;

	// Shared multiplier.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod_q;

	// Stored ack.
	logic [31:0] stored_num_q;
	logic [31:0] stored_csum_q;
	logic        ack_written_q;

	// Reply sequencer.
	logic          mode_q;
	logic [CW-1:0] idx_q;
	logic          rd_pend_s1;
	logic [IW-1:0] idx_s1;
	logic          issue;

	// Output register.
	logic [7:0]  out_byte_q;
	logic [31:0] out_num_q;
	logic [31:0] out_csum_q;
	logic        out_verdict_q;
	logic        out_last_q;

	// Input beat fields.
	logic [7:0]  in_byte;
	logic        in_take;
	logic        in_range;
	logic [31:0] byte_term;
	logic [31:0] sum_fin;

	// RAM ports.
	logic [7:0] rx_rd;
	logic [7:0] ack_rd;
	logic [7:0] reply_byte;
	logic       ack_wr;

	assign in_byte   = s_tdata[7:0];
	assign s_tready  = (state_q == S_IN);
	assign in_take   = s_tvalid && s_tready;
	assign in_range  = (pos_q < POS_MAX);
	assign byte_term = 32'(pos_q) * {{24{in_byte[7]}}, in_byte};
	assign sum_fin   = payload_sum_q + (in_range ? byte_term : 32'd0);

	// Multiplier operand selection: header products, then scaling by the index total.
	always_comb begin
		mul_a = prod_q;
		mul_b = IDX_TOTAL;
		case (state_q)
			S_H1: begin
				mul_a = 32'd1 + ack_q;
				mul_b = 32'd2 + seq_q;
			end
			S_A1: begin
				mul_a = 32'd1 + seq_q;
				mul_b = 32'd2 + seq_q;
			end
			default: begin
				mul_a = prod_q;
				mul_b = IDX_TOTAL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// A reply read goes out only when the output register is free on the next cycle.
	assign issue = (state_q == S_REPLY) && (idx_q != POS_MAX) && !rd_pend_s1
		&& (!m_tvalid || m_tready);

	// Receive buffer: written by input beats, read during a new-ack reply; the two
	// never overlap because input is held off during the reply.
	abr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (in_take && in_range),
		.wr_addr (pos_q[IW-1:0]),
		.wr_data (in_byte),
		.rd_en   (issue),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (rx_rd)
	);

	// Stored ack payload: read on a replay, written on a new ack, never both at once.
	abr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_ack_ram (
		.clk     (clk),
		.wr_en   (ack_wr),
		.wr_addr (idx_s1),
		.wr_data (reply_byte),
		.rd_en   (issue),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (ack_rd)
	);

	// Byte of the reply: stored ack on a replay (0x61 before any ack is written), received byte or zero past the end.
	always_comb begin
		if (mode_q == VERDICT_REPLAY) begin
			reply_byte = ack_written_q ? ack_rd : FILL_BYTE;
		end else begin
			reply_byte = (CW'(idx_s1) < count_q) ? rx_rd : 8'h00;
		end
	end

	assign ack_wr = rd_pend_s1 && (mode_q == VERDICT_NEW);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IN;
			pos_q         <= '0;
			payload_sum_q <= '0;
			stored_num_q  <= INIT_ACK;
			stored_csum_q <= RESET_CSUM;
			ack_written_q <= 1'b0;
			mode_q        <= VERDICT_NEW;
			idx_q         <= '0;
			rd_pend_s1    <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				S_IN: begin
					if (in_take) begin
						if (s_tlast) begin
							pos_q         <= '0;
							payload_sum_q <= '0;
							state_q       <= S_H1;
						end else begin
							payload_sum_q <= sum_fin;
							if (in_range) begin
								pos_q <= pos_q + CW'(1);
							end
						end
					end
				end
				S_H1: begin
					state_q <= S_H2;
				end
				S_H2: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					idx_q <= '0;
					if (pcs_q != sum_q + prod_q) begin
						state_q <= S_IN;
					end else if (seq_q == stored_num_q) begin
						mode_q  <= VERDICT_REPLAY;
						state_q <= S_REPLY;
					end else begin
						state_q <= S_A1;
					end
				end
				S_A1: begin
					state_q <= S_A2;
				end
				S_A2: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					// The new ack replaces the stored one; its payload lands during the reply.
					stored_csum_q <= sum_q + prod_q;
					stored_num_q  <= seq_q;
					ack_written_q <= 1'b1;
					mode_q        <= VERDICT_NEW;
					state_q       <= S_REPLY;
				end
				S_REPLY: begin
					if (rd_pend_s1 && (idx_s1 == IDX_LAST)) begin
						state_q <= S_IN;
					end
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

	// Header and totals of the packet, taken on its last beat; reply read index kept on each read.
	always_ff @(posedge clk) begin
		if (in_take && s_tlast) begin
			seq_q   <= s_tdata[39:8];
			ack_q   <= s_tdata[71:40];
			pcs_q   <= s_tdata[103:72];
			sum_q   <= sum_fin;
			count_q <= pos_q + CW'(in_range);
		end
		if (issue) begin
			idx_s1 <= idx_q[IW-1:0];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rd_pend_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output register payload, loaded when read data returns.
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_byte_q    <= reply_byte;
			out_num_q     <= stored_num_q;
			out_csum_q    <= stored_csum_q;
			out_verdict_q <= mode_q;
			out_last_q    <= (idx_s1 == IDX_LAST);
		end
	end

	assign m_tdata = {out_byte_q, out_csum_q, out_num_q};
	assign m_tuser = {(out_verdict_q == VERDICT_NEW), out_verdict_q};
	assign m_tlast = out_last_q;

	// Read data must find the output register empty, or a beat would be lost.
	`ASSERT_CLK(a_load_free, rd_pend_s1 |-> !m_tvalid, "reply beat overwrote a pending beat")
	// Reads are only in flight while a reply is being sent.
	`ASSERT_CLK(a_read_in_reply, rd_pend_s1 |-> (state_q == S_REPLY), "read outside reply")
	// The checksum compare always follows the scaled header product.
	`ASSERT_CLK(a_chk_order, (state_q == S_CHK) |-> ($past(state_q) == S_H2),
		"checksum compare without header product")

endmodule

`default_nettype wire
